>>> rtl/bhs_pkg.sv
// shared types and constants of the two-axis bresenham step interpolator
package bhs_pkg;

  // default parameter values
  localparam int PULSE_LEN_DEF  = 20;
  localparam int TICK_RATE_DEF  = 10;
  localparam int MAX_GAP_DEF    = 32767;
  localparam int COUNT_BITS_DEF = 24;

  // fixed field widths
  localparam int INTERVAL_W = 16;
  localparam int PULSE_W    = 10;
  localparam int GAP_W      = 15;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;

  // output tdata packing
  localparam int OUT_DATA_W = 96;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THETA_COUNT   = 2'd0,
    CFG_RHO_COUNT     = 2'd1,
    CFG_THETA_REVERSE = 2'd2,
    CFG_RHO_REVERSE   = 2'd3
  } cfg_reg_t;

  // per-slot step decision for both axes
  typedef struct packed {
    logic theta;
    logic rho;
  } step_flags_t;

  // axis directions
  typedef struct packed {
    logic theta_reverse;
    logic rho_reverse;
  } dir_flags_t;

endpackage

>>> rtl/bhs_cfg_regs.sv
// configuration registers: per-axis step counts and directions
module bhs_cfg_regs #(
  parameter int COUNT_BITS = bhs_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bhs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [COUNT_BITS-1:0]          wr_data,
  output logic [COUNT_BITS-1:0]          theta_count,
  output logic [COUNT_BITS-1:0]          rho_count,
  output bhs_pkg::dir_flags_t            dir
);

  logic [COUNT_BITS-1:0] theta_count_r;
  logic [COUNT_BITS-1:0] rho_count_r;
  bhs_pkg::dir_flags_t   dir_r;

  // register write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_count_r <= '0;
      rho_count_r   <= '0;
      dir_r         <= '0;
    end else if (wr_en) begin
      unique case (bhs_pkg::cfg_reg_t'(wr_index))
        bhs_pkg::CFG_THETA_COUNT:   theta_count_r       <= wr_data;
        bhs_pkg::CFG_RHO_COUNT:     rho_count_r         <= wr_data;
        bhs_pkg::CFG_THETA_REVERSE: dir_r.theta_reverse <= wr_data[0];
        bhs_pkg::CFG_RHO_REVERSE:   dir_r.rho_reverse   <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign theta_count = theta_count_r;
  assign rho_count   = rho_count_r;
  assign dir         = dir_r;

endmodule

>>> rtl/bhs_interp.sv
// bresenham step decision and next state for one slot
module bhs_interp #(
  parameter int COUNT_BITS = bhs_pkg::COUNT_BITS_DEF
) (
  input  logic [COUNT_BITS-1:0]        theta_count,
  input  logic [COUNT_BITS-1:0]        rho_count,
  input  bhs_pkg::dir_flags_t          dir,
  input  logic                         first_step,
  input  logic [COUNT_BITS-1:0]        theta_left,
  input  logic [COUNT_BITS-1:0]        rho_left,
  input  logic [COUNT_BITS+1:0]        error_term,
  input  logic [bhs_pkg::POS_W-1:0]    theta_loc,
  input  logic [bhs_pkg::POS_W-1:0]    rho_loc,
  output bhs_pkg::step_flags_t         steps,
  output logic [COUNT_BITS-1:0]        theta_left_nxt,
  output logic [COUNT_BITS-1:0]        rho_left_nxt,
  output logic [COUNT_BITS+1:0]        error_term_nxt,
  output logic [bhs_pkg::POS_W-1:0]    theta_loc_nxt,
  output logic [bhs_pkg::POS_W-1:0]    rho_loc_nxt
);

  localparam int ERR_W = COUNT_BITS + 2;

  logic                  theta_major;
  logic [COUNT_BITS-1:0] major;
  logic [COUNT_BITS-1:0] minor;
  logic [COUNT_BITS-1:0] tl;
  logic [COUNT_BITS-1:0] rl;
  logic [ERR_W-1:0]      e0;
  logic [ERR_W-1:0]      e1;
  logic [ERR_W-1:0]      e2;
  logic                  neg;
  logic                  active;
  logic                  theta_has;
  logic                  rho_has;

  // major axis selection, theta wins a tie
  assign theta_major = (theta_count >= rho_count);
  assign major = theta_major ? theta_count : rho_count;
  assign minor = theta_major ? rho_count : theta_count;

  // reload on the first slot of a segment
  assign tl = first_step ? theta_count : theta_left;
  assign rl = first_step ? rho_count : rho_left;
  assign e0 = first_step ? {3'b000, major[COUNT_BITS-1:1]} : error_term;

  assign theta_has = (tl != '0);
  assign rho_has   = (rl != '0);
  assign active    = theta_has || rho_has;

  // error update wraps in its own width
  assign e1  = e0 - {2'b00, minor};
  assign neg = e1[ERR_W-1];
  assign e2  = neg ? (e1 + {2'b00, major}) : e1;

  // step flags
  always_comb begin
    steps.theta = active && theta_has && (theta_major || neg);
    steps.rho   = active && rho_has && (!theta_major || neg);
  end

  // next state
  assign error_term_nxt = active ? e2 : e0;
  assign theta_left_nxt = steps.theta ? (tl - 1'b1) : tl;
  assign rho_left_nxt   = steps.rho ? (rl - 1'b1) : rl;

  always_comb begin
    theta_loc_nxt = theta_loc;
    if (steps.theta) begin
      theta_loc_nxt = dir.theta_reverse ? (theta_loc - 1'b1) : (theta_loc + 1'b1);
    end
    rho_loc_nxt = rho_loc;
    if (steps.rho) begin
      rho_loc_nxt = dir.rho_reverse ? (rho_loc - 1'b1) : (rho_loc + 1'b1);
    end
  end

endmodule

>>> rtl/bhs_gap.sv
// low gap in ticks from the slot interval
module bhs_gap #(
  parameter int PULSE_LEN = bhs_pkg::PULSE_LEN_DEF,
  parameter int TICK_RATE = bhs_pkg::TICK_RATE_DEF,
  parameter int MAX_GAP   = bhs_pkg::MAX_GAP_DEF
) (
  input  logic [bhs_pkg::INTERVAL_W-1:0] slot_usec,
  output logic [bhs_pkg::GAP_W-1:0]      gap_ticks
);

  localparam int TOT_W = bhs_pkg::INTERVAL_W + $clog2(TICK_RATE + 1) + 1;
  localparam logic [TOT_W-1:0] CAP   = TOT_W'(MAX_GAP + PULSE_LEN);
  localparam logic [TOT_W-1:0] PULSE = TOT_W'(PULSE_LEN);
  localparam logic [TOT_W-1:0] TPU   = TOT_W'(TICK_RATE);

  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] clamped;
  logic [TOT_W-1:0] gap;

  // constant multiply, clamp, then take off the pulse half
  assign total   = {{(TOT_W-bhs_pkg::INTERVAL_W){1'b0}}, slot_usec} * TPU;
  assign clamped = (total > CAP) ? CAP : total;
  assign gap     = (clamped > PULSE) ? (clamped - PULSE) : TOT_W'(1);
  assign gap_ticks = gap[bhs_pkg::GAP_W-1:0];

endmodule

>>> rtl/two_axis_bresenham_step_symbols_core.sv
// top level of the two-axis bresenham step interpolator
//
// Usage: write each axis's step count and direction on the cfg channel
// (index 0 theta count, 1 rho count, 2 theta reverse, 3 rho reverse),
// then stream one transfer per step slot on in_: tdata carries the interval
// in microseconds, tuser the first-step flag, tlast the final-step flag.
// Each input transfer gives exactly one out_ transfer: tuser holds the
// theta and rho step flags, tlast echoes final-step, tdata holds pulse
// width, gap in ticks and both wrapping axis positions.
// The input register captures each input transfer, and the result register
// takes the slot from it while the receiver is not stalling; out_tvalid
// rises as the result register fills.
// Throughput is one item per cycle while out_tready stays high; the
// Bresenham state feeds back through its own state registers.
// Reset clears the configuration, the remaining counts, the error term and
// both positions, and empties both registers. When the receiver stalls the
// result register holds, the input register fills and in_tready drops;
// in_tready follows out_tready again in the same cycle once it rises.
module two_axis_bresenham_step_symbols_core #(
  parameter int PULSE_LEN  = bhs_pkg::PULSE_LEN_DEF,
  parameter int TICK_RATE  = bhs_pkg::TICK_RATE_DEF,
  parameter int MAX_GAP    = bhs_pkg::MAX_GAP_DEF,
  parameter int COUNT_BITS = bhs_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bhs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [COUNT_BITS-1:0]           cfg_data,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] slot interval in us
  input  logic [0:0]                      in_tuser,   // [0] first step flag
  input  logic                            in_tlast,   // final step flag
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [9:0] pulse width, [24:10] gap ticks, [56:25] theta position,
  // [88:57] rho position, [95:89] zero
  output logic [bhs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser,  // [0] theta pulse, [1] rho pulse
  output logic                            out_tlast   // segment end
);

  localparam int ERR_W = COUNT_BITS + 2;
  localparam int PAD_W = bhs_pkg::OUT_DATA_W - bhs_pkg::PULSE_W - bhs_pkg::GAP_W
                         - 2 * bhs_pkg::POS_W;

  logic [COUNT_BITS-1:0] theta_count;
  logic [COUNT_BITS-1:0] rho_count;
  bhs_pkg::dir_flags_t   dir;

  // input register
  logic                            in_valid_r;
  logic [bhs_pkg::INTERVAL_W-1:0]  interval_r;
  logic                            first_r;
  logic                            final_r;

  // bresenham state
  logic [COUNT_BITS-1:0]        theta_left_r, theta_left_nxt;
  logic [COUNT_BITS-1:0]        rho_left_r, rho_left_nxt;
  logic [ERR_W-1:0]             error_term_r, error_term_nxt;
  logic [bhs_pkg::POS_W-1:0]    theta_loc_r, theta_loc_nxt;
  logic [bhs_pkg::POS_W-1:0]    rho_loc_r, rho_loc_nxt;

  // result register
  logic                         out_valid_r;
  bhs_pkg::step_flags_t         steps_r, steps_nxt;
  logic [bhs_pkg::GAP_W-1:0]    gap_r, gap_nxt;
  logic [bhs_pkg::POS_W-1:0]    theta_out_r;
  logic [bhs_pkg::POS_W-1:0]    rho_out_r;
  logic                         seg_end_r;

  logic advance;

  assign cfg_ready = 1'b1;

  bhs_cfg_regs #(
    .COUNT_BITS(COUNT_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_valid && cfg_ready),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .theta_count(theta_count),
    .rho_count  (rho_count),
    .dir        (dir)
  );

  // flow control
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      interval_r <= in_tdata[bhs_pkg::INTERVAL_W-1:0];
      first_r    <= in_tuser[0];
      final_r    <= in_tlast;
    end
  end

  bhs_interp #(
    .COUNT_BITS(COUNT_BITS)
  ) u_interp (
    .theta_count   (theta_count),
    .rho_count     (rho_count),
    .dir           (dir),
    .first_step    (first_r),
    .theta_left    (theta_left_r),
    .rho_left      (rho_left_r),
    .error_term    (error_term_r),
    .theta_loc     (theta_loc_r),
    .rho_loc       (rho_loc_r),
    .steps         (steps_nxt),
    .theta_left_nxt(theta_left_nxt),
    .rho_left_nxt  (rho_left_nxt),
    .error_term_nxt(error_term_nxt),
    .theta_loc_nxt (theta_loc_nxt),
    .rho_loc_nxt   (rho_loc_nxt)
  );

  bhs_gap #(
    .PULSE_LEN(PULSE_LEN),
    .TICK_RATE(TICK_RATE),
    .MAX_GAP  (MAX_GAP)
  ) u_gap (
    .slot_usec(interval_r),
    .gap_ticks(gap_nxt)
  );

  // state update once per slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_left_r <= '0;
      rho_left_r   <= '0;
      error_term_r <= '0;
      theta_loc_r  <= '0;
      rho_loc_r    <= '0;
    end else if (advance) begin
      theta_left_r <= theta_left_nxt;
      rho_left_r   <= rho_left_nxt;
      error_term_r <= error_term_nxt;
      theta_loc_r  <= theta_loc_nxt;
      rho_loc_r    <= rho_loc_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      steps_r     <= steps_nxt;
      gap_r       <= gap_nxt;
      theta_out_r <= theta_loc_nxt;
      rho_out_r   <= rho_loc_nxt;
      seg_end_r   <= final_r;
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, rho_out_r, theta_out_r, gap_r,
                       bhs_pkg::PULSE_W'(PULSE_LEN)};
  assign out_tuser  = {steps_r.rho, steps_r.theta};
  assign out_tlast  = seg_end_r;

endmodule
